### design/dtf_pkg.sv
`default_nettype none
package dtf_pkg;

    localparam int DEF_MAX_FRAC_DIGITS = 7;
    localparam int DEF_FRAC_BITS       = 24;

    localparam int CH_W    = 8;
    localparam int VALUE_W = 56;
    localparam int INT_W   = 31;
    localparam int DIGIT_W = 4;
    localparam int MAG_W   = 64;

    localparam logic [INT_W-1:0]   INT_MAX_VAL = {INT_W{1'b1}};
    localparam logic [VALUE_W-1:0] MAG_MAX     = {1'b0, {(VALUE_W-1){1'b1}}};

    // queue between parser and converter
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_W-1:0] CH_DOT   = 8'd46;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SUM,
        BK_DONE
    } t_bstate;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [31:0] pow10(input logic [DIGIT_W-1:0] k);
        logic [31:0] p;
        case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

### design/dtf_char_if.sv
`default_nettype none
interface dtf_char_if
    import dtf_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface
`default_nettype wire

### design/dtf_fix_if.sv
`default_nettype none
interface dtf_fix_if
    import dtf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      int_overflow;
    logic                      fraction_dropped;

    modport source (output valid, output value, output int_overflow,
                    output fraction_dropped, input ready);
    modport sink   (input valid, input value, input int_overflow,
                    input fraction_dropped, output ready);
endinterface
`default_nettype wire

### design/decimal_text_to_fixed.sv
// Decimal text to signed fixed point.
// i_char takes one ASCII character per word; last marks the final character
// of a string. o_fix gives one word per string: value in two's complement
// with FRAC_BITS fraction bits, plus int_overflow (integer part saturated)
// and fraction_dropped (too many fraction digits, fraction forced to zero).
// The parser takes one character per cycle while the queue is not full. On
// the last character it hands the parsed fields to a two-entry queue and
// starts the next string at once. The converter pops an entry and divides
// the fraction digits by the power of ten one quotient bit per cycle in
// BK_DIV, skipped when there are no fraction digits. A result passes the
// queue and the states BK_IDLE, BK_DIV, BK_SUM and BK_DONE, and BK_DONE
// loads the output register that drives o_fix.valid. A new entry is popped
// only in BK_IDLE, so the converter works on one string at a time.
// When o_fix is stalled the result holds in the output register; the
// converter finishes the next string and waits, the queue fills, and then
// i_char.ready drops.
// After reset the parser is in leading whitespace and the queue is empty.
`default_nettype none
module decimal_text_to_fixed
    import dtf_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
    parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    dtf_char_if.sink  i_char,
    dtf_fix_if.source o_fix
);
    localparam int FA_W  = $clog2(10 ** MAX_FRAC_DIGITS);
    localparam int CW    = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int JOB_W = 3 + INT_W + FA_W + CW;

    logic             push, pop;
    logic [JOB_W-1:0] job_in, job_out;
    t_qstat           qstat;

    dtf_front #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .JOB_W           (JOB_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (job_in)
    );

    dtf_queue #(
        .W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_stat  (qstat)
    );

    dtf_back #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .FRAC_BITS       (FRAC_BITS),
        .JOB_W           (JOB_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_fix   (o_fix)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("queue read while empty");

    a_drop_zero_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_fix.valid && o_fix.fraction_dropped) |-> (o_fix.value[FRAC_BITS-1:0] == '0))
        else $error("dropped fraction left fraction bits set");
`endif

endmodule
`default_nettype wire

### design/dtf_front.sv
`default_nettype none
module dtf_front
    import dtf_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
    parameter int JOB_W           = 1
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    dtf_char_if.sink          i_char,
    input  t_qstat            i_qstat,
    output logic              o_push,
    output logic [JOB_W-1:0]  o_job
);
    localparam int FA_W = $clog2(10 ** MAX_FRAC_DIGITS);
    localparam int CW   = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int IW   = INT_W + 4;

    t_phase          r_phase, n_phase, p_phase;
    logic            r_neg, n_neg, p_neg;
    logic [INT_W-1:0] r_int, n_int, p_int;
    logic [FA_W-1:0] r_frac, n_frac, p_frac;
    logic [CW-1:0]   r_cnt, n_cnt, p_cnt;
    logic            r_ovf, n_ovf, p_ovf;
    logic            r_drop, n_drop, p_drop;

    logic               accept;
    logic               is_digit;
    logic               is_space;
    logic [DIGIT_W-1:0] digit;
    logic [CH_W-1:0]    ch_off;
    logic [IW-1:0]      int_next;
    logic               int_sat;

    assign i_char.ready = !i_qstat.full;
    assign accept       = i_char.valid && i_char.ready;

    assign ch_off   = i_char.ch - CH_ZERO;
    assign digit    = ch_off[DIGIT_W-1:0];
    assign is_digit = (i_char.ch >= CH_ZERO) && (i_char.ch <= CH_NINE);
    assign is_space = (i_char.ch == CH_SPACE) ||
                      ((i_char.ch >= CH_TAB) && (i_char.ch <= CH_CR));

    // times ten as shift and add
    assign int_next = (IW'(r_int) << 3) + (IW'(r_int) << 1) + IW'(digit);
    assign int_sat  = int_next > IW'(INT_MAX_VAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_drop  <= n_drop;
        end
    end

    always_comb begin
        p_phase = r_phase;
        p_neg   = r_neg;
        p_int   = r_int;
        p_frac  = r_frac;
        p_cnt   = r_cnt;
        p_ovf   = r_ovf;
        p_drop  = r_drop;

        unique case (r_phase)
            PH_LEAD: begin
                if (is_space) begin
                    p_phase = PH_LEAD;
                end else if (i_char.ch == CH_MINUS) begin
                    p_neg   = 1'b1;
                    p_phase = PH_INT;
                end else if (i_char.ch == CH_PLUS) begin
                    p_phase = PH_INT;
                end else if (is_digit) begin
                    p_int   = int_sat ? INT_MAX_VAL : int_next[INT_W-1:0];
                    p_ovf   = r_ovf || int_sat;
                    p_phase = PH_INT;
                end else if (i_char.ch == CH_DOT) begin
                    p_phase = PH_FRAC;
                end else begin
                    p_phase = PH_STOP;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    p_int = int_sat ? INT_MAX_VAL : int_next[INT_W-1:0];
                    p_ovf = r_ovf || int_sat;
                end else if (i_char.ch == CH_DOT) begin
                    p_phase = PH_FRAC;
                end else begin
                    p_phase = PH_STOP;
                end
            end
            PH_FRAC: begin
                if (!is_digit) begin
                    p_phase = PH_STOP;
                end else if (r_cnt >= CW'(MAX_FRAC_DIGITS)) begin
                    // one digit too many: drop the whole fraction
                    p_frac  = '0;
                    p_cnt   = '0;
                    p_drop  = 1'b1;
                    p_phase = PH_STOP;
                end else begin
                    p_frac = FA_W'((FA_W + 4)'(r_frac) * (FA_W + 4)'(10)
                                   + (FA_W + 4)'(digit));
                    p_cnt  = r_cnt + 1'b1;
                end
            end
            PH_STOP: begin
                p_phase = PH_STOP;
            end
            default: begin
                p_phase = PH_STOP;
            end
        endcase

        n_phase = r_phase;
        n_neg   = r_neg;
        n_int   = r_int;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_drop  = r_drop;
        o_push  = 1'b0;

        if (accept) begin
            if (i_char.last) begin
                o_push  = 1'b1;
                n_phase = PH_LEAD;
                n_neg   = 1'b0;
                n_int   = '0;
                n_frac  = '0;
                n_cnt   = '0;
                n_ovf   = 1'b0;
                n_drop  = 1'b0;
            end else begin
                n_phase = p_phase;
                n_neg   = p_neg;
                n_int   = p_int;
                n_frac  = p_frac;
                n_cnt   = p_cnt;
                n_ovf   = p_ovf;
                n_drop  = p_drop;
            end
        end
    end

    assign o_job = {p_neg, p_ovf, p_drop, p_int, p_frac, p_cnt};

endmodule
`default_nettype wire

### design/dtf_queue.sv
`default_nettype none
module dtf_queue
    import dtf_pkg::*;
#(
    parameter int W = 1
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire [W-1:0]  i_data,
    input  wire          i_pop,
    output logic [W-1:0] o_data,
    output t_qstat       o_stat
);
    logic [W-1:0]       r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

### design/dtf_back.sv
`default_nettype none
module dtf_back
    import dtf_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
    parameter int FRAC_BITS       = DEF_FRAC_BITS,
    parameter int JOB_W           = 1
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [JOB_W-1:0]  i_job,
    input  t_qstat           i_qstat,
    output logic             o_pop,
    dtf_fix_if.source        o_fix
);
    localparam int FA_W = $clog2(10 ** MAX_FRAC_DIGITS);
    localparam int CW   = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int DW   = FA_W;
    localparam int NW   = FA_W + FRAC_BITS + 1;
    localparam int SW   = $clog2(FRAC_BITS + 1);

    logic             job_neg, job_ovf, job_drop;
    logic [INT_W-1:0] job_int;
    logic [FA_W-1:0]  job_frac;
    logic [CW-1:0]    job_cnt;

    assign {job_neg, job_ovf, job_drop, job_int, job_frac, job_cnt} = i_job;

    t_bstate r_state, n_state;

    logic               r_neg, r_ovf, r_drop;
    logic [INT_W-1:0]   r_int;
    logic [DW-1:0]      r_den;
    logic [DW-1:0]      r_rem;
    logic [FRAC_BITS:0] r_low;
    logic [FRAC_BITS:0] r_quo;
    logic [SW-1:0]      r_step;
    logic [MAG_W-1:0]   r_mag;

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_out_ovf, r_out_drop;

    logic [DW-1:0]      den;
    logic [NW-1:0]      num_init;
    logic [DW:0]        trial;
    logic               ge;
    logic [DW:0]        diff;
    logic               out_load;
    logic [VALUE_W-1:0] mag_clamped;

    assign den      = DW'(pow10(DIGIT_W'(job_cnt)));
    // rounding bias of half the divisor goes in up front
    assign num_init = (NW'(job_frac) << FRAC_BITS) + NW'(den >> 1);

    assign trial = {r_rem, r_low[FRAC_BITS]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    assign mag_clamped = (r_mag > MAG_W'(MAG_MAX)) ? MAG_MAX : r_mag[VALUE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = (job_cnt == '0) ? BK_SUM : BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == '0) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                n_state = BK_DONE;
            end
            BK_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_fix.ready) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg  <= job_neg;
            r_ovf  <= job_ovf;
            r_drop <= job_drop;
            r_int  <= job_int;
            r_den  <= den;
            r_rem  <= num_init[NW-1:FRAC_BITS+1];
            r_low  <= num_init[FRAC_BITS:0];
            r_quo  <= '0;
            r_step <= SW'(FRAC_BITS);
        end else if (r_state == BK_DIV) begin
            r_rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_low  <= {r_low[FRAC_BITS-1:0], 1'b0};
            r_quo  <= {r_quo[FRAC_BITS-1:0], ge};
            r_step <= r_step - 1'b1;
        end
        if (r_state == BK_SUM) begin
            r_mag <= (MAG_W'(r_int) << FRAC_BITS) + MAG_W'(r_quo);
        end
        if (out_load) begin
            r_value    <= r_neg ? -mag_clamped : mag_clamped;
            r_out_ovf  <= r_ovf;
            r_out_drop <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_fix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_fix.valid            = r_out_valid;
    assign o_fix.value            = r_value;
    assign o_fix.int_overflow     = r_out_ovf;
    assign o_fix.fraction_dropped = r_out_drop;

endmodule
`default_nettype wire

### verif/fixed_result_checker.sv
`timescale 1ns / 1ps
module fixed_result_checker
    import dtf_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    dtf_char_if  i_char,
    dtf_fix_if   i_fix,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int FRAC_DIGITS_MAX = DEF_MAX_FRAC_DIGITS;
    localparam int FRAC_W          = DEF_FRAC_BITS;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      int_overflow;
        logic                      fraction_dropped;
    } t_fix_word;

    // parse state of the string in flight
    t_phase             num_phase;
    logic               num_negative;
    logic [INT_W-1:0]   int_part;
    logic [FRAC_W-1:0]  frac_digits;
    logic [2:0]         frac_digit_cnt;
    logic               int_saturated;
    logic               frac_dropped;

    t_fix_word          expected_fix_q[$];
    t_fix_word          exp_word;
    int                 mismatch_cnt;

    function automatic void clear_number();
        num_phase      = PH_LEAD;
        num_negative   = 1'b0;
        int_part       = '0;
        frac_digits    = '0;
        frac_digit_cnt = '0;
        int_saturated  = 1'b0;
        frac_dropped   = 1'b0;
    endfunction

    function automatic void add_int_digit(input logic [DIGIT_W-1:0] d);
        logic [63:0] nxt;
        nxt = 64'(int_part) * 64'd10 + 64'(d);
        if (nxt > 64'(INT_MAX_VAL)) begin
            int_part      = INT_MAX_VAL;
            int_saturated = 1'b1;
        end else begin
            int_part = nxt[INT_W-1:0];
        end
    endfunction

    function automatic void add_frac_digit(input logic [DIGIT_W-1:0] d);
        logic [31:0] nxt;
        if (int'(frac_digit_cnt) >= FRAC_DIGITS_MAX) begin
            // one digit too many: drop the whole fraction and stop parsing
            frac_digits    = '0;
            frac_digit_cnt = '0;
            frac_dropped   = 1'b1;
            num_phase      = PH_STOP;
        end else begin
            nxt            = 32'(frac_digits) * 32'd10 + 32'(d);
            frac_digits    = nxt[FRAC_W-1:0];
            frac_digit_cnt = frac_digit_cnt + 3'd1;
        end
    endfunction

    function automatic t_fix_word finish_number();
        logic [63:0] den;
        logic [63:0] frac;
        logic [63:0] mag;
        t_fix_word   w;
        frac = '0;
        if (frac_digit_cnt != 0) begin
            den = 64'd1;
            repeat (int'(frac_digit_cnt)) den = den * 64'd10;
            frac = ((64'(frac_digits) << FRAC_W) + den / 64'd2) / den;
        end
        mag = (64'(int_part) << FRAC_W) + frac;
        if (mag > 64'(MAG_MAX))
            mag = 64'(MAG_MAX);
        if (num_negative)
            mag = 64'd0 - mag;
        w.value            = mag[VALUE_W-1:0];
        w.int_overflow     = int_saturated;
        w.fraction_dropped = frac_dropped;
        return w;
    endfunction

    function automatic void absorb_char(input logic [CH_W-1:0] c, input logic is_last);
        logic               is_digit;
        logic               is_space;
        logic [DIGIT_W-1:0] d;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        d        = c[DIGIT_W-1:0];
        case (num_phase)
            PH_LEAD: begin
                if (is_space) begin
                end else if (c == CH_MINUS) begin
                    num_negative = 1'b1;
                    num_phase    = PH_INT;
                end else if (c == CH_PLUS) begin
                    num_phase = PH_INT;
                end else if (is_digit) begin
                    add_int_digit(d);
                    num_phase = PH_INT;
                end else if (c == CH_DOT) begin
                    num_phase = PH_FRAC;
                end else begin
                    num_phase = PH_STOP;
                end
            end
            PH_INT: begin
                if (is_digit)
                    add_int_digit(d);
                else if (c == CH_DOT)
                    num_phase = PH_FRAC;
                else
                    num_phase = PH_STOP;
            end
            PH_FRAC: begin
                if (is_digit)
                    add_frac_digit(d);
                else
                    num_phase = PH_STOP;
            end
            default: num_phase = PH_STOP;
        endcase
        if (is_last) begin
            expected_fix_q.push_back(finish_number());
            clear_number();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_number();
            expected_fix_q.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_char.valid && i_char.ready)
                absorb_char(i_char.ch, i_char.last);
            if (i_fix.valid && i_fix.ready) begin
                if (expected_fix_q.size() == 0) begin
                    $error("unexpected result word: value %0d", i_fix.value);
                    mismatch_cnt++;
                end else begin
                    exp_word = expected_fix_q.pop_front();
                    if (i_fix.value !== exp_word.value) begin
                        $error("value: expected %0d, actual %0d",
                               $signed(exp_word.value), i_fix.value);
                        mismatch_cnt++;
                    end
                    if (i_fix.int_overflow !== exp_word.int_overflow) begin
                        $error("int_overflow: expected %0b, actual %0b",
                               exp_word.int_overflow, i_fix.int_overflow);
                        mismatch_cnt++;
                    end
                    if (i_fix.fraction_dropped !== exp_word.fraction_dropped) begin
                        $error("fraction_dropped: expected %0b, actual %0b",
                               exp_word.fraction_dropped, i_fix.fraction_dropped);
                        mismatch_cnt++;
                    end
                end
            end
        end
        o_pending    <= expected_fix_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

### verif/tb_decimal_text_to_fixed.sv
`timescale 1ns / 1ps
module tb_decimal_text_to_fixed;
    import dtf_pkg::*;

    localparam int CHAR_TARGET     = 1600;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PAUSE_AT_TEXT   = 100;

    logic i_clk;
    logic i_rst_n;

    dtf_char_if char_bus ();
    dtf_fix_if  fix_bus ();

    int   fail_count;
    int   pending_words;
    int   cycle_cnt;
    int   chars_sent;
    logic hold_off_go;
    bit   no_gap_text;

    logic [CH_W-1:0] text_q[$];

    decimal_text_to_fixed u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_fix   (fix_bus)
    );

    fixed_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (char_bus),
        .i_fix        (fix_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap_text || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void append_text(input string s);
        foreach (s[i]) text_q.push_back(s[i]);
    endfunction

    function automatic logic [CH_W-1:0] rand_digit();
        return CH_ZERO + CH_W'($urandom_range(0, 9));
    endfunction

    task automatic send_char(input logic [CH_W-1:0] c, input logic is_last, input int gap);
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.ch    <= c;
        char_bus.last  <= is_last;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
    endtask

    // counted: characters of the string that add to chars_sent
    task automatic send_text(input int counted);
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1, pick_gap());
        chars_sent += counted;
        text_q.delete();
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    // mostly well-formed numbers with random content, some noise
    task automatic build_random_text(output int counted);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) text_q.push_back(CH_W'($urandom_range(0, 255)));
            counted = n;
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 2);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0)
                    text_q.push_back(CH_SPACE);
                else
                    text_q.push_back(CH_W'($urandom_range(CH_TAB, CH_CR)));
            end
        end
        case ($urandom_range(0, 3))
            1: text_q.push_back(CH_MINUS);
            2: text_q.push_back(CH_PLUS);
            default: ;
        endcase
        r = $urandom_range(0, 99);
        if (r < 5) begin
            // right at the saturation boundary
            if ($urandom_range(0, 1) == 0)
                append_text("2147483647");
            else
                append_text("2147483648");
        end else begin
            if (r < 13)
                n = 0;
            else if (r < 82)
                n = $urandom_range(1, 4);
            else if (r < 93)
                n = $urandom_range(5, 9);
            else
                n = $urandom_range(10, 11);
            repeat (n) text_q.push_back(rand_digit());
        end
        if ($urandom_range(0, 9) < 7) begin
            text_q.push_back(CH_DOT);
            r = $urandom_range(0, 99);
            if (r < 10)
                n = 0;
            else if (r < 88)
                n = $urandom_range(1, 7);
            else
                n = $urandom_range(8, 9);
            repeat (n) text_q.push_back(rand_digit());
        end
        if (text_q.size() == 0)
            text_q.push_back(rand_digit());
        counted = text_q.size();
        // trailing junk: breaks the pattern or gets ignored
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) text_q.push_back(CH_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin : fix_sink
        int  r;
        int  run_len;
        int  stall_len;
        bit  hold_done;
        hold_done = 1'b0;
        fix_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_go && !hold_done) begin
                // hold off long enough for the block to back up into its input
                hold_done = 1'b1;
                fix_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    run_len = $urandom_range(40, 150);
                else
                    run_len = $urandom_range(1, 8);
                fix_bus.ready <= 1'b1;
                repeat (run_len) @(posedge i_clk);
                r = $urandom_range(0, 99);
                if (r < 40)
                    stall_len = 0;
                else if (r < 92)
                    stall_len = $urandom_range(1, 3);
                else
                    stall_len = $urandom_range(15, 60);
                if (stall_len > 0) begin
                    fix_bus.ready <= 1'b0;
                    repeat (stall_len) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : char_source
        int counted;
        int text_idx;
        i_rst_n        <= 1'b0;
        char_bus.valid <= 1'b0;
        char_bus.ch    <= '0;
        char_bus.last  <= 1'b0;
        hold_off_go    <= 1'b0;
        chars_sent      = 0;
        text_idx        = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings: code extremes, whitespace, both signs, negative zero,
        // ignored tail, leading dot, dropped fraction, saturated integer
        text_q.push_back(8'hFF);
        send_text(1);
        text_q.push_back(8'h00);
        send_text(1);
        text_q.push_back(CH_CR);
        append_text("-0");
        send_text(3);
        append_text("+3.5x9");
        send_text(6);
        append_text(".12345678");
        send_text(9);
        append_text("4294967296");
        send_text(10);

        // sender keeps pushing without gaps while the receiver holds off
        hold_off_go <= 1'b1;
        no_gap_text  = 1'b1;
        repeat (24) begin
            build_random_text(counted);
            send_text(counted);
        end

        while (chars_sent < CHAR_TARGET) begin
            no_gap_text = ($urandom_range(0, 4) == 0);
            build_random_text(counted);
            send_text(counted);
            text_idx++;
            if (text_idx == PAUSE_AT_TEXT) begin
                char_bus.valid <= 1'b0;
                wait_for_results();
            end
        end
        char_bus.valid <= 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
